/* hdl/ir_pulse_distance_decoder_macros.svh */
// Assertion macros used by the checker file of the infrared decoder.
`ifndef IR_PULSE_DISTANCE_DECODER_MACROS_SVH
`define IR_PULSE_DISTANCE_DECODER_MACROS_SVH

// Same-cycle implication, switched off while dis is high.
`define IPD_ASSERT_IMPLY(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, switched off while dis is high.
`define IPD_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hdl/ipd_pkg.sv */
// Shared types and constants of the infrared pulse-distance decoder.
package ipd_pkg;

    localparam int TICK_W         = 16;
    localparam int KEY_W          = 8;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int FRAME_W        = 32;
    localparam int FRAME_IDX_W    = $clog2(FRAME_W);
    localparam int KEY_IDX_W      = 2;
    localparam int FRAME_BITS_DEF = 32;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 40;
    localparam int M_FIELDS_W     = 35;

    localparam logic [TICK_W-1:0] START_LOW_RST  = 16'd8000;
    localparam logic [TICK_W-1:0] START_HIGH_RST = 16'd14000;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST   = 16'd700;
    localparam logic [TICK_W-1:0] BIT_SPLIT_RST  = 16'd1450;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 16'd3000;
    localparam logic [KEY_W-1:0]  KEY_CODE_A_RST = 8'h0c;
    localparam logic [KEY_W-1:0]  KEY_CODE_B_RST = 8'h18;
    localparam logic [KEY_W-1:0]  KEY_CODE_C_RST = 8'h5e;

    localparam logic [KEY_IDX_W-1:0] KEY_IDX_A    = 2'd0;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_B    = 2'd1;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_C    = 2'd2;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_NONE = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_LOW  = 3'd0,
        CFG_START_HIGH = 3'd1,
        CFG_ZERO_LOW   = 3'd2,
        CFG_BIT_SPLIT  = 3'd3,
        CFG_ONE_HIGH   = 3'd4,
        CFG_KEY_CODE_A = 3'd5,
        CFG_KEY_CODE_B = 3'd6,
        CFG_KEY_CODE_C = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [TICK_W-1:0] start_low;
        logic [TICK_W-1:0] start_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] bit_split;
        logic [TICK_W-1:0] one_high;
        logic [KEY_W-1:0]  key_code_a;
        logic [KEY_W-1:0]  key_code_b;
        logic [KEY_W-1:0]  key_code_c;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic one;
        logic zero;
    } pulse_class_t;

endpackage

/* hdl/ir_pulse_distance_decoder.sv */
// Top level of the infrared pulse-distance frame decoder.
// The decoder accepts one edge interval per clock cycle unless the input side stalls. An
// accepted interval waits in the input register until the output side can take a result;
// then the window compare and frame update consume it, and the interval that completes a
// frame loads the output register, which holds a result until it is taken, and the input
// side stalls only while both registers are full and m_tready is low. Registers are written
// through cfg_wr_en, cfg_index and cfg_data and take effect in the following cycle.
module ir_pulse_distance_decoder #(
    parameter int FRAME_BITS = ipd_pkg::FRAME_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: interval_ticks[15:0].
    input  logic [ipd_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: check_ok, address_byte, address_check, command_byte,
    // command_check, key_index, then zero padding.
    output logic [ipd_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipd_pkg::CFG_W-1:0]      cfg_data
);

    ipd_pkg::cfg_t                cfg;
    ipd_pkg::pulse_class_t        cls;
    logic                         in_valid_reg, in_valid_next;
    logic [ipd_pkg::TICK_W-1:0]   ticks_reg;
    logic                         out_ready;
    logic                         advance;
    logic                         done;
    logic [ipd_pkg::FRAME_W-1:0]  frame_next;

    assign out_ready = !m_tvalid || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ticks_reg <= s_tdata[ipd_pkg::TICK_W-1:0];
        end
    end

    ipd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipd_window u_window (
        .ticks (ticks_reg),
        .cfg   (cfg),
        .cls   (cls)
    );

    ipd_frame #(
        .FRAME_BITS (FRAME_BITS)
    ) u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .cls        (cls),
        .done       (done),
        .frame_next (frame_next)
    );

    ipd_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .done     (done),
        .frame    (frame_next),
        .cfg      (cfg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

/* hdl/ipd_cfg_regs.sv */
// Configuration register bank of the infrared decoder.
module ipd_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipd_pkg::CFG_W-1:0]      cfg_data,
    output ipd_pkg::cfg_t                  cfg
);

    ipd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low  <= ipd_pkg::START_LOW_RST;
            cfg_reg.start_high <= ipd_pkg::START_HIGH_RST;
            cfg_reg.zero_low   <= ipd_pkg::ZERO_LOW_RST;
            cfg_reg.bit_split  <= ipd_pkg::BIT_SPLIT_RST;
            cfg_reg.one_high   <= ipd_pkg::ONE_HIGH_RST;
            cfg_reg.key_code_a <= ipd_pkg::KEY_CODE_A_RST;
            cfg_reg.key_code_b <= ipd_pkg::KEY_CODE_B_RST;
            cfg_reg.key_code_c <= ipd_pkg::KEY_CODE_C_RST;
        end else if (cfg_wr_en) begin
            unique case (ipd_pkg::cfg_index_t'(cfg_index))
                ipd_pkg::CFG_START_LOW:  cfg_reg.start_low  <= cfg_data;
                ipd_pkg::CFG_START_HIGH: cfg_reg.start_high <= cfg_data;
                ipd_pkg::CFG_ZERO_LOW:   cfg_reg.zero_low   <= cfg_data;
                ipd_pkg::CFG_BIT_SPLIT:  cfg_reg.bit_split  <= cfg_data;
                ipd_pkg::CFG_ONE_HIGH:   cfg_reg.one_high   <= cfg_data;
                ipd_pkg::CFG_KEY_CODE_A: cfg_reg.key_code_a <= cfg_data[ipd_pkg::KEY_W-1:0];
                ipd_pkg::CFG_KEY_CODE_B: cfg_reg.key_code_b <= cfg_data[ipd_pkg::KEY_W-1:0];
                ipd_pkg::CFG_KEY_CODE_C: cfg_reg.key_code_c <= cfg_data[ipd_pkg::KEY_W-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/ipd_window.sv */
// Window comparators that classify one edge interval.
module ipd_window (
    input  logic [ipd_pkg::TICK_W-1:0] ticks,
    input  ipd_pkg::cfg_t              cfg,
    output ipd_pkg::pulse_class_t      cls
);

    always_comb begin
        cls.start = (ticks > cfg.start_low) && (ticks < cfg.start_high);
        cls.one   = (ticks > cfg.bit_split) && (ticks < cfg.one_high);
        cls.zero  = (ticks > cfg.zero_low)  && (ticks < cfg.bit_split);
    end

endmodule

/* hdl/ipd_frame.sv */
// Frame assembly: open flag, bit counter and the received frame bits.
module ipd_frame #(
    parameter int FRAME_BITS = ipd_pkg::FRAME_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  ipd_pkg::pulse_class_t        cls,
    output logic                         done,
    output logic [ipd_pkg::FRAME_W-1:0]  frame_next
);

    localparam int CNT_W = $clog2(FRAME_BITS);
    localparam int POS_W = (CNT_W > ipd_pkg::FRAME_IDX_W) ? CNT_W : ipd_pkg::FRAME_IDX_W + 1;

    logic                        open_reg, open_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [ipd_pkg::FRAME_W-1:0] frame_reg;
    logic [POS_W-1:0]            pos;
    logic                        pos_in_frame;
    logic                        bit_seen;
    logic                        last_bit;

    assign pos          = POS_W'(cnt_reg);
    assign pos_in_frame = pos < POS_W'(ipd_pkg::FRAME_W);
    assign bit_seen     = open_reg && (cls.one || cls.zero);
    assign last_bit     = cnt_reg == CNT_W'(FRAME_BITS - 1);

    always_comb begin
        open_next  = open_reg;
        cnt_next   = cnt_reg;
        frame_next = frame_reg;
        done       = 1'b0;
        if (advance) begin
            priority if (cls.start) begin
                open_next = 1'b1;
                cnt_next  = '0;
            end else if (bit_seen) begin
                if (pos_in_frame) begin
                    frame_next[pos[ipd_pkg::FRAME_IDX_W-1:0]] = cls.one;
                end
                if (last_bit) begin
                    open_next = 1'b0;
                    cnt_next  = '0;
                    done      = 1'b1;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end else begin
                open_next = open_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg  <= 1'b0;
            cnt_reg   <= '0;
            frame_reg <= '0;
        end else begin
            open_reg  <= open_next;
            cnt_reg   <= cnt_next;
            frame_reg <= frame_next;
        end
    end

endmodule

/* hdl/ipd_out.sv */
// Result formatting and the output register of the result channel.
module ipd_out (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           done,
    input  logic [ipd_pkg::FRAME_W-1:0]    frame,
    input  ipd_pkg::cfg_t                  cfg,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [ipd_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic [ipd_pkg::KEY_W-1:0]      addr_b, addr_chk, cmd_b, cmd_chk;
    logic [ipd_pkg::KEY_IDX_W-1:0]  key_idx;
    logic                           check_ok;
    logic                           valid_reg, valid_next;
    logic [ipd_pkg::M_TDATA_W-1:0]  data_reg;

    assign addr_b   = frame[7:0];
    assign addr_chk = frame[15:8];
    assign cmd_b    = frame[23:16];
    assign cmd_chk  = frame[31:24];
    assign check_ok = cmd_b == ~cmd_chk;

    always_comb begin
        priority if (cmd_b == cfg.key_code_a) begin
            key_idx = ipd_pkg::KEY_IDX_A;
        end else if (cmd_b == cfg.key_code_b) begin
            key_idx = ipd_pkg::KEY_IDX_B;
        end else if (cmd_b == cfg.key_code_c) begin
            key_idx = ipd_pkg::KEY_IDX_C;
        end else begin
            key_idx = ipd_pkg::KEY_IDX_NONE;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (done) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            data_reg <= {{(ipd_pkg::M_TDATA_W - ipd_pkg::M_FIELDS_W){1'b0}},
                         key_idx, cmd_chk, cmd_b, addr_chk, addr_b, check_ok};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

/* hdl/ipd_checker.sv */
// Port-level checker of the infrared decoder and its bind to the top level.
`include "ir_pulse_distance_decoder_macros.svh"

module ipd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ipd_pkg::M_TDATA_W-1:0]  m_tdata
);

    // A result that is not taken stays on the port unchanged.
    `IPD_ASSERT_NEXT(a_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The check flag agrees with the two command bytes it reports.
    `IPD_ASSERT_IMPLY(a_check, aclk, !aresetn, m_tvalid, m_tdata[0] == (m_tdata[24:17] == ~m_tdata[32:25]))

    // The padding above the result fields is zero whenever a result is valid.
    `IPD_ASSERT_IMPLY(a_pad, aclk, !aresetn, m_tvalid, m_tdata[ipd_pkg::M_TDATA_W-1:ipd_pkg::M_FIELDS_W] == '0)

    // Reset empties the output register and leaves the input side ready.
    `IPD_ASSERT_NEXT(a_reset, aclk, 1'b0, !aresetn, !m_tvalid && s_tready)

endmodule

bind ir_pulse_distance_decoder ipd_checker u_ipd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
